### rtl/core/jls_pkg.sv
// Shared types and codes for the Jacobi linear solver.
package jls_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_A   = 2'd0,
        OP_LOAD_B   = 2'd1,
        OP_SOLVE    = 2'd2,
        OP_RESERVED = 2'd3
    } op_t;

    typedef enum logic {
        REG_SIZE  = 1'b0,
        REG_ITERS = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW,
        ST_MAC,
        ST_DRAIN,
        ST_NEG,
        ST_NUM,
        ST_DSET,
        ST_DIV,
        ST_WRITE,
        ST_OUT_RD,
        ST_OUT
    } state_t;

    localparam logic [15:0] ITERS_RESET = 16'd100;
    localparam logic [5:0]  SIZE_RESET  = 6'd32;
    localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [31:0] X_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] X_MIN = 32'h8000_0000;

endpackage

### rtl/core/jacobi_linear_solver_top.sv
// Top level of the Jacobi linear solver: storage, sequencer and shared arithmetic.
//
// Load beats (matrix or right-hand-side entry) are taken one per cycle while idle.
// A solve beat runs iteration_count sweeps; each row passes through the single
// multiply-accumulate pipeline and then, when its diagonal is non-zero, through the
// bit-serial divider. The n solution beats then follow, each read from the solution
// memory before it is offered, and no new input is accepted until the last
// of them has been taken.
module jacobi_linear_solver_top
    import jls_pkg::*;
#(
    parameter int MAX_SIZE  = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [4:0]         row,
    input  logic [4:0]         col,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [4:0]         index,
    output logic signed [31:0] x_value,
    output logic               saturated,
    output logic               last
);

    localparam int AW = $clog2(MAX_SIZE);
    localparam int CW = $clog2(MAX_SIZE + 1);

    state_t state_reg, state_next;

    logic [5:0]  size_reg;
    logic [15:0] iters_reg;

    logic signed [31:0] coeff_mem [0:(1 << (2 * AW)) - 1];
    logic signed [31:0] rhs_mem   [0:MAX_SIZE - 1];
    logic signed [31:0] sol_mem   [0:(2 << AW) - 1];

    logic signed [31:0] c_rd_reg, s_rd_reg, rhs_rd_reg;

    logic [CW-1:0] n_reg, i_reg, j_reg, oi_reg;
    logic [15:0]   k_reg;
    logic          first_reg, zero_out_reg, flag_reg;
    logic          p1_v_reg, p1_d_reg, p2_v_reg;
    logic signed [63:0] prod_reg, acc_reg, neg_reg, num_reg;
    logic signed [31:0] diag_reg;
    logic [63:0]   dvd_reg;
    logic [31:0]   dsr_reg;
    logic [31:0]   rem_reg;
    logic [5:0]    dcnt_reg;
    logic [MAX_SIZE-1:0] sat_reg;

    logic          in_acc, out_acc;
    logic [CW-1:0] n_clamped;
    logic signed [63:0] rhs_scaled;
    logic signed [64:0] acc_sum, num_sum;
    logic [32:0]   div_trial;
    logic          div_ge;
    logic [31:0]   x_res;
    logic          x_sat;
    logic [AW:0]   sol_waddr, sol_raddr;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_comb
    begin
        if (size_reg == 6'd0)
            n_clamped = CW'(1);
        else if (32'(size_reg) > MAX_SIZE)
            n_clamped = CW'(MAX_SIZE);
        else
            n_clamped = CW'(size_reg);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc && op == OP_SOLVE)
                    state_next = (iters_reg == 16'd0) ? ST_OUT_RD : ST_ROW;
            ST_ROW:    state_next = ST_MAC;
            ST_MAC:    if (j_reg == n_reg - CW'(1)) state_next = ST_DRAIN;
            ST_DRAIN:  if (!p1_v_reg && !p1_d_reg && !p2_v_reg) state_next = ST_NEG;
            ST_NEG:    state_next = ST_NUM;
            ST_NUM:    state_next = ST_DSET;
            ST_DSET:   state_next = (diag_reg == 32'sd0) ? ST_WRITE : ST_DIV;
            ST_DIV:    if (dcnt_reg == 6'd63) state_next = ST_WRITE;
            ST_WRITE:
                if (i_reg == n_reg - CW'(1) && k_reg == iters_reg - 16'd1)
                    state_next = ST_OUT_RD;
                else
                    state_next = ST_ROW;
            ST_OUT_RD: state_next = ST_OUT;
            ST_OUT:
                if (out_acc)
                    state_next = (oi_reg == n_reg - CW'(1)) ? ST_IDLE : ST_OUT_RD;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        index     = 5'(oi_reg);
        x_value   = zero_out_reg ? 32'sd0 : s_rd_reg;
        saturated = sat_reg[oi_reg[AW-1:0]];
        last      = (oi_reg == n_reg - CW'(1));
    end

    always_comb
    begin
        rhs_scaled = 64'(rhs_rd_reg) <<< FRAC_BITS;
        acc_sum    = {acc_reg[63], acc_reg} + {prod_reg[63], prod_reg};
        num_sum    = {rhs_scaled[63], rhs_scaled} + {neg_reg[63], neg_reg};
        div_trial  = {rem_reg, dvd_reg[63]};
        div_ge     = (div_trial >= {1'b0, dsr_reg});
    end

    // Quotient sign follows the operand signs; the result is clamped to the signed 32-bit range.
    always_comb
    begin
        x_sat = 1'b0;
        x_res = 32'd0;
        if (diag_reg == 32'sd0)
        begin
            x_sat = 1'b1;
            x_res = num_reg[63] ? X_MIN : X_MAX;
        end
        else if (num_reg[63] == diag_reg[31])
        begin
            if (dvd_reg > 64'(X_MAX))
            begin
                x_sat = 1'b1;
                x_res = X_MAX;
            end
            else
                x_res = dvd_reg[31:0];
        end
        else
        begin
            if (dvd_reg > 64'(X_MIN))
            begin
                x_sat = 1'b1;
                x_res = X_MIN;
            end
            else
                x_res = 32'd0 - dvd_reg[31:0];
        end
    end

    always_comb
    begin
        sol_waddr = {k_reg[0], i_reg[AW-1:0]};
        if (state_reg == ST_MAC)
            sol_raddr = {~k_reg[0], j_reg[AW-1:0]};
        else
            sol_raddr = {k_reg[0], oi_reg[AW-1:0]};
    end

    // Memories.
    always_ff @(posedge clk)
    begin
        if (in_acc && op == OP_LOAD_A && 32'(row) < MAX_SIZE && 32'(col) < MAX_SIZE)
            coeff_mem[{AW'(row), AW'(col)}] <= value;
        if (in_acc && op == OP_LOAD_B && 32'(row) < MAX_SIZE)
            rhs_mem[AW'(row)] <= value;
        if (state_reg == ST_WRITE)
            sol_mem[sol_waddr] <= x_res;
        c_rd_reg   <= coeff_mem[{i_reg[AW-1:0], j_reg[AW-1:0]}];
        s_rd_reg   <= sol_mem[sol_raddr];
        rhs_rd_reg <= rhs_mem[i_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            size_reg     <= SIZE_RESET;
            iters_reg    <= ITERS_RESET;
            n_reg        <= CW'(1);
            i_reg        <= '0;
            j_reg        <= '0;
            oi_reg       <= '0;
            k_reg        <= '0;
            first_reg    <= 1'b0;
            zero_out_reg <= 1'b0;
            flag_reg     <= 1'b0;
            p1_v_reg     <= 1'b0;
            p1_d_reg     <= 1'b0;
            p2_v_reg     <= 1'b0;
            dcnt_reg     <= '0;
            sat_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_SIZE)
                    size_reg <= cfg_data[5:0];
                else
                    iters_reg <= cfg_data;
            end

            p1_v_reg <= (state_reg == ST_MAC) && (j_reg != i_reg);
            p1_d_reg <= (state_reg == ST_MAC) && (j_reg == i_reg);
            p2_v_reg <= p1_v_reg;

            unique case (state_reg)
                ST_IDLE:
                    if (in_acc && op == OP_SOLVE)
                    begin
                        n_reg        <= n_clamped;
                        i_reg        <= '0;
                        k_reg        <= '0;
                        oi_reg       <= '0;
                        first_reg    <= 1'b1;
                        zero_out_reg <= (iters_reg == 16'd0);
                        sat_reg      <= '0;
                    end
                ST_ROW:
                begin
                    j_reg    <= '0;
                    flag_reg <= 1'b0;
                end
                ST_MAC:
                    j_reg <= j_reg + CW'(1);
                ST_DRAIN,
                ST_NEG,
                ST_NUM,
                ST_DSET,
                ST_DIV:
                    ;
                ST_WRITE:
                begin
                    if (flag_reg || x_sat)
                        sat_reg[i_reg[AW-1:0]] <= 1'b1;
                    if (i_reg == n_reg - CW'(1))
                    begin
                        if (k_reg != iters_reg - 16'd1)
                        begin
                            i_reg     <= '0;
                            k_reg     <= k_reg + 16'd1;
                            first_reg <= 1'b0;
                        end
                    end
                    else
                        i_reg <= i_reg + CW'(1);
                end
                ST_OUT_RD:
                    ;
                ST_OUT:
                    if (out_acc)
                        oi_reg <= oi_reg + CW'(1);
                default:
                    ;
            endcase

            if (state_reg == ST_NEG && acc_reg == ACC_MIN)
                flag_reg <= 1'b1;
            if (state_reg == ST_NUM && num_sum[64] != num_sum[63])
                flag_reg <= 1'b1;
            if (p2_v_reg && acc_sum[64] != acc_sum[63])
                flag_reg <= 1'b1;
            if (state_reg == ST_DSET)
                dcnt_reg <= '0;
            else if (state_reg == ST_DIV)
                dcnt_reg <= dcnt_reg + 6'd1;
        end
    end

    // Multiply-accumulate pipeline and divider datapath.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ROW)
            acc_reg <= 64'sd0;
        else if (p2_v_reg)
        begin
            if (acc_sum[64] != acc_sum[63])
                acc_reg <= acc_sum[64] ? ACC_MIN : ACC_MAX;
            else
                acc_reg <= acc_sum[63:0];
        end
        if (p1_v_reg)
            prod_reg <= c_rd_reg * (first_reg ? 32'sd0 : s_rd_reg);
        if (p1_d_reg)
            diag_reg <= c_rd_reg;
        if (state_reg == ST_NEG)
            neg_reg <= (acc_reg == ACC_MIN) ? ACC_MAX : -acc_reg;
        if (state_reg == ST_NUM)
        begin
            if (num_sum[64] != num_sum[63])
                num_reg <= num_sum[64] ? ACC_MIN : ACC_MAX;
            else
                num_reg <= num_sum[63:0];
        end
        if (state_reg == ST_DSET)
        begin
            dvd_reg <= num_reg[63] ? (64'd0 - 64'(num_reg)) : 64'(num_reg);
            dsr_reg <= diag_reg[31] ? (32'd0 - 32'(diag_reg)) : 32'(diag_reg);
            rem_reg <= 32'd0;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= div_ge ? 32'(div_trial - {1'b0, dsr_reg}) : div_trial[31:0];
            dvd_reg <= {dvd_reg[62:0], div_ge};
        end
    end

    a_no_input_while_output: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while a solution beat is pending");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (dsr_reg != 32'd0))
        else $error("divider running with a zero divisor");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && last) |=> (state_reg == ST_IDLE))
        else $error("solver did not return to idle after the last beat");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the Jacobi linear solver, with its own fixed-point solve predictor.
module tb_top
    import jls_pkg::*;
;

    localparam int N_MAX = 32;
    localparam int WATCHDOG_LIMIT = 3000000;

    typedef struct packed {
        logic [4:0]  index;
        logic [31:0] x_value;
        logic        saturated;
        logic        last;
    } solution_beat_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [15:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [1:0] op;
    logic [4:0] row;
    logic [4:0] col;
    logic signed [31:0] value;
    logic out_valid;
    logic out_stall;
    logic [4:0] index;
    logic signed [31:0] x_value;
    logic saturated;
    logic last;

    jacobi_linear_solver_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .row(row), .col(col), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .index(index), .x_value(x_value), .saturated(saturated), .last(last)
    );

    // Predictor state.
    logic signed [31:0] coeff [N_MAX][N_MAX];
    logic signed [31:0] rhs [N_MAX];
    logic [5:0] size_reg;
    logic [15:0] sweeps_reg;
    solution_beat_t solution_q[$];

    int mismatches;
    int idle_cycles;
    int stall_left;
    bit quiet;
    bit hold_req;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int active_size();
        if (size_reg == 0)
            return 1;
        if (size_reg > N_MAX)
            return N_MAX;
        return size_reg;
    endfunction

    function automatic longint add_clamped(longint a, longint b, inout bit flag);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            flag = 1'b1;
            s = a[63] ? ACC_MIN : ACC_MAX;
        end
        return s;
    endfunction

    // Runs every sweep of one solve and queues the beats it must emit.
    function automatic void predict_solution();
        logic signed [31:0] x_prev [N_MAX];
        logic signed [31:0] x_next [N_MAX];
        bit sat_row [N_MAX];
        int n;
        longint acc;
        longint neg;
        longint num;
        longint q;
        bit flag;
        solution_beat_t beat;
        n = active_size();
        for (int i = 0; i < N_MAX; i++)
        begin
            x_prev[i] = '0;
            x_next[i] = '0;
            sat_row[i] = 1'b0;
        end
        for (int k = 0; k < sweeps_reg; k++)
        begin
            for (int i = 0; i < n; i++)
            begin
                flag = 1'b0;
                acc = 0;
                for (int j = 0; j < n; j++)
                    if (j != i)
                        acc = add_clamped(acc, longint'(coeff[i][j]) * longint'(x_prev[j]), flag);
                if (acc == ACC_MIN)
                begin
                    flag = 1'b1;
                    neg = ACC_MAX;
                end
                else
                    neg = -acc;
                num = add_clamped(longint'(rhs[i]) * 64'sd65536, neg, flag);
                if (coeff[i][i] == 0)
                begin
                    flag = 1'b1;
                    x_next[i] = (num >= 0) ? X_MAX : X_MIN;
                end
                else if (num == ACC_MIN && coeff[i][i] == -1)
                begin
                    flag = 1'b1;
                    x_next[i] = X_MAX;
                end
                else
                begin
                    q = num / longint'(coeff[i][i]);
                    if (q > 64'sh7FFF_FFFF)
                    begin
                        flag = 1'b1;
                        x_next[i] = X_MAX;
                    end
                    else if (q < -64'sh8000_0000)
                    begin
                        flag = 1'b1;
                        x_next[i] = X_MIN;
                    end
                    else
                        x_next[i] = q[31:0];
                end
                if (flag)
                    sat_row[i] = 1'b1;
            end
            x_prev = x_next;
        end
        for (int i = 0; i < n; i++)
        begin
            beat.index = i[4:0];
            beat.x_value = x_next[i];
            beat.saturated = sat_row[i];
            beat.last = (i == n - 1);
            solution_q.push_back(beat);
        end
    endfunction

    // Called at a rising edge; returns at the edge that takes the beat.
    task automatic send_item(op_t o, logic [4:0] r, logic [4:0] c, logic [31:0] v);
        int gap;
        bit taken;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        row <= r;
        col <= c;
        value <= v;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        case (o)
            OP_LOAD_A: coeff[r][c] = v;
            OP_LOAD_B: rhs[r] = v;
            OP_SOLVE:  predict_solution();
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (solution_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SIZE)
            size_reg = d[5:0];
        else
            sweeps_reg = d;
    endtask

    function automatic logic [31:0] pick_value(bit tame);
        case ($urandom_range(0, 5))
            0: return X_MAX;
            1: return X_MIN;
            default: return tame ? 32'($urandom_range(0, 131072)) - 32'd65536 : $urandom;
        endcase
    endfunction

    // Writes every entry the coming solve will read. A tame system gets a large
    // diagonal and mostly small other entries, though extreme values can still appear.
    task automatic load_system(bit tame);
        int n;
        logic [31:0] v;
        n = active_size();
        for (int i = 0; i < n; i++)
        begin
            send_item(OP_LOAD_B, i[4:0], 5'($urandom), pick_value(tame));
            for (int j = 0; j < n; j++)
            begin
                if (i == j && tame)
                    v = 32'((n + 2 + $urandom_range(0, 3)) * 65536)
                        * ($urandom_range(0, 1) ? 32'd1 : -32'd1);
                else
                    v = pick_value(tame);
                send_item(OP_LOAD_A, i[4:0], j[4:0], v);
            end
        end
    endtask

    task automatic test_directed_extremes();
        write_reg(REG_SIZE, 16'd2);
        write_reg(REG_ITERS, 16'd3);
        send_item(OP_LOAD_A, 5'd0, 5'd0, 32'd1);
        send_item(OP_LOAD_A, 5'd0, 5'd1, X_MAX);
        send_item(OP_LOAD_A, 5'd1, 5'd0, X_MIN);
        send_item(OP_LOAD_A, 5'd1, 5'd1, 32'hFFFF_FFFF);
        send_item(OP_LOAD_B, 5'd0, 5'd31, X_MAX);
        send_item(OP_LOAD_B, 5'd1, 5'd0, X_MIN);
        // Entries beyond the size in use are stored but never read.
        send_item(OP_LOAD_A, 5'd31, 5'd31, 32'h5A5A_A5A5);
        send_item(OP_LOAD_B, 5'd31, 5'd31, 32'hA5A5_5A5A);
        send_item(OP_RESERVED, 5'd31, 5'd31, 32'hFFFF_FFFF);
        send_item(OP_SOLVE, 5'd0, 5'd0, 32'd0);
        // A zero diagonal with a negative and a positive difference.
        send_item(OP_LOAD_A, 5'd0, 5'd0, 32'd0);
        send_item(OP_LOAD_A, 5'd1, 5'd1, 32'd0);
        send_item(OP_LOAD_B, 5'd0, 5'd0, 32'd65536);
        send_item(OP_SOLVE, 5'd31, 5'd31, 32'hFFFF_FFFF);
        wait_idle();
        write_reg(REG_ITERS, 16'd0);
        send_item(OP_SOLVE, 5'd0, 5'd0, 32'd0);
        wait_idle();
    endtask

    task automatic test_size_limits();
        write_reg(REG_ITERS, 16'd2);
        write_reg(REG_SIZE, 16'd0);
        load_system(1'b1);
        send_item(OP_SOLVE, 5'd0, 5'd0, 32'd0);
        wait_idle();
        // Without sweeps nothing is read, so the widest sizes need no loads.
        write_reg(REG_ITERS, 16'd0);
        write_reg(REG_SIZE, 16'd63);
        send_item(OP_SOLVE, 5'd0, 5'd0, 32'd0);
        wait_idle();
        write_reg(REG_SIZE, 16'd32);
        send_item(OP_SOLVE, 5'd0, 5'd0, 32'd0);
        wait_idle();
    endtask

    task automatic test_longest_sweep_count();
        // A zero diagonal skips the divider, which keeps the longest count affordable.
        write_reg(REG_SIZE, 16'd1);
        write_reg(REG_ITERS, 16'hFFFF);
        send_item(OP_LOAD_A, 5'd0, 5'd0, 32'd0);
        send_item(OP_LOAD_B, 5'd0, 5'd3, 32'hFFFF_0000);
        send_item(OP_SOLVE, 5'd0, 5'd0, 32'd0);
        wait_idle();
    endtask

    task automatic test_output_hold();
        write_reg(REG_SIZE, 16'd4);
        write_reg(REG_ITERS, 16'd0);
        load_system(1'b1);
        hold_req = 1'b1;
        send_item(OP_SOLVE, 5'd0, 5'd0, 32'd0);
        // The block refuses these until the held-off beats have drained.
        send_item(OP_LOAD_B, 5'd2, 5'd9, 32'd131072);
        send_item(OP_LOAD_A, 5'd3, 5'd1, 32'hFFFE_0000);
        send_item(OP_SOLVE, 5'd0, 5'd0, 32'd0);
        wait_idle();
    endtask

    task automatic test_random_solves();
        int sent;
        int n;
        int pick;
        sent = 0;
        while (sent < 90)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            write_reg(REG_SIZE, 16'($urandom_range(1, 5)));
            write_reg(REG_ITERS, 16'($urandom_range(0, 12)));
            n = active_size();
            load_system($urandom_range(0, 3) != 0);
            sent += n * (n + 1);
            repeat ($urandom_range(4, 12))
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    send_item(OP_LOAD_A, 5'($urandom_range(0, n - 1)),
                              5'($urandom_range(0, n - 1)), pick_value(1'b0));
                else if (pick < 6)
                    send_item(OP_LOAD_B, 5'($urandom_range(0, n - 1)), 5'($urandom),
                              pick_value(1'b1));
                else if (pick < 7)
                    send_item(OP_LOAD_A, 5'($urandom), 5'($urandom), $urandom);
                else if (pick < 8)
                    send_item(OP_RESERVED, 5'($urandom), 5'($urandom), $urandom);
                else
                    send_item(OP_SOLVE, 5'($urandom), 5'($urandom), $urandom);
                sent++;
            end
            send_item(OP_SOLVE, 5'($urandom), 5'($urandom), $urandom);
            sent++;
            wait_idle();
        end
        quiet = 1'b0;
    endtask

    // Receiver stall: a drawn gap before each beat, or one long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Result checker and watchdog, sampled mid-cycle where everything is settled.
    initial
    begin
        solution_beat_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                stall_left = quiet ? 0 : $urandom_range(0, 12);
                if (solution_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: index %0d x %h sat %b last %b",
                                 index, x_value, saturated, last);
                end
                else
                begin
                    want = solution_q.pop_front();
                    if (want.index !== index || want.x_value !== x_value
                        || want.saturated !== saturated || want.last !== last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected index %0d x %h sat %b last %b,",
                                     want.index, want.x_value, want.saturated, want.last,
                                     " got index %0d x %h sat %b last %b",
                                     index, x_value, saturated, last);
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        op = '0;
        row = '0;
        col = '0;
        value = '0;
        mismatches = 0;
        idle_cycles = 0;
        stall_left = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        size_reg = SIZE_RESET;
        sweeps_reg = ITERS_RESET;
        for (int i = 0; i < N_MAX; i++)
        begin
            rhs[i] = '0;
            for (int j = 0; j < N_MAX; j++)
                coeff[i][j] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_size_limits();
        test_longest_sweep_count();
        test_output_hold();
        test_random_solves();

        if (solution_q.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
